### sv/pecg_pkg.sv
// constants and tables shared by the peaking eq coefficient generator
package pecg_pkg;

    localparam int          QF           = 30;
    localparam logic [31:0] TWO_PI_LO    = 32'd2451551556;  // round(2pi*2^30) minus 2^32
    localparam logic [31:0] PI_Q30       = 32'd3373259426;
    localparam logic [31:0] HALF_PI_Q30  = 32'd1686629713;
    localparam logic [29:0] KINV_Q30     = 30'd652032874;
    localparam logic [29:0] LN2_Q30      = 30'd744261118;
    localparam logic [26:0] GAIN_EXP_Q30 = 27'd89172328;
    localparam logic [17:0] FS_RESET     = 18'd48000;
    localparam logic [5:0]  U_INT_MAX    = 6'd56;

    localparam logic [1:0]  STAT_OK      = 2'd0;
    localparam logic [1:0]  STAT_BAD_F0  = 2'd1;
    localparam logic [1:0]  STAT_SAT     = 2'd2;

    localparam logic [29:0] ATAN_Q30 [0:31] = '{
        30'd843314856, 30'd497837829, 30'd263043836, 30'd133525158, 30'd67021686,
        30'd33543515, 30'd16775850, 30'd8388437, 30'd4194282, 30'd2097149,
        30'd1048575, 30'd524287, 30'd262143, 30'd131071, 30'd65535, 30'd32767,
        30'd16383, 30'd8191, 30'd4095, 30'd2047, 30'd1023, 30'd511, 30'd255,
        30'd127, 30'd63, 30'd31, 30'd15, 30'd8, 30'd4, 30'd2, 30'd1, 30'd0
    };

endpackage

### sv/pecg_div.sv
// pipelined restoring divider, one quotient bit per stage, with sideband
module pecg_div #(
    parameter int NW = 8,
    parameter int DW = 4,
    parameter int QW = 4,
    parameter int PW = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_vld,
    input  logic [NW-1:0] i_n,
    input  logic [DW-1:0] i_d,
    input  logic [PW-1:0] i_side,
    output logic          o_vld,
    output logic [QW-1:0] o_q,
    output logic          o_ovf,
    output logic [PW-1:0] o_side
);
    localparam int HW = NW - QW;
    localparam int CW = (HW > DW) ? HW : DW;

    logic          r_vld  [0:QW];
    logic [DW-1:0] r_rem  [0:QW];
    logic [QW-1:0] r_lo   [0:QW];
    logic [QW-1:0] r_q    [0:QW];
    logic [DW-1:0] r_d    [0:QW];
    logic          r_ovf  [0:QW];
    logic [PW-1:0] r_side [0:QW];

    logic [CW-1:0] w_h;
    logic [CW-1:0] w_dx;

    assign w_h  = CW'(i_n[NW-1:QW]);
    assign w_dx = CW'(i_d);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_vld;
        end
    end

    // quotient too wide when the high part already reaches the divisor
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]  <= w_h[DW-1:0];
            r_lo[0]   <= i_n[QW-1:0];
            r_q[0]    <= '0;
            r_d[0]    <= i_d;
            r_ovf[0]  <= (w_h >= w_dx);
            r_side[0] <= i_side;
        end
    end

    for (genvar k = 1; k <= QW; k++) begin : g_stage
        logic [DW:0] w_t;
        logic        w_ge;

        assign w_t  = {r_rem[k-1], r_lo[k-1][QW-1]};
        assign w_ge = (w_t >= {1'b0, r_d[k-1]});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= r_vld[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= w_ge ? DW'(w_t - {1'b0, r_d[k-1]}) : DW'(w_t);
                r_lo[k]   <= r_lo[k-1] << 1;
                r_q[k]    <= {r_q[k-1][QW-2:0], w_ge};
                r_d[k]    <= r_d[k-1];
                r_ovf[k]  <= r_ovf[k-1];
                r_side[k] <= r_side[k-1];
            end
        end
    end

    assign o_vld  = r_vld[QW];
    assign o_q    = r_q[QW];
    assign o_ovf  = r_ovf[QW];
    assign o_side = r_side[QW];

endmodule

### sv/pecg_exp2.sv
// pipelined 2^f for a q30 fraction, sixteen term taylor series of e^(f ln2)
module pecg_exp2 #(
    parameter int PW = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_vld,
    input  logic [29:0]   i_f,
    input  logic [PW-1:0] i_side,
    output logic          o_vld,
    output logic [30:0]   o_p,
    output logic [PW-1:0] o_side
);
    localparam int NT = 16;

    // stage a: product, stage b: reciprocal estimate, stage c: corrected term
    logic          r_avld [1:NT];
    logic [29:0]   r_av   [1:NT];
    logic [29:0]   r_ay   [1:NT];
    logic [30:0]   r_asum [1:NT];
    logic [PW-1:0] r_aside[1:NT];
    logic          r_bvld [1:NT];
    logic [29:0]   r_bv   [1:NT];
    logic [29:0]   r_bq0  [1:NT];
    logic [29:0]   r_by   [1:NT];
    logic [30:0]   r_bsum [1:NT];
    logic [PW-1:0] r_bside[1:NT];
    logic          r_cvld [0:NT];
    logic [30:0]   r_cterm[0:NT];
    logic [29:0]   r_cy   [0:NT];
    logic [30:0]   r_csum [0:NT];
    logic [PW-1:0] r_cside[0:NT];

    logic [60:0]   w_y;

    assign w_y = 61'(i_f) * 61'(pecg_pkg::LN2_Q30) + (61'd1 << 29);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cvld[0] <= 1'b0;
        end else if (i_en) begin
            r_cvld[0] <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cterm[0] <= 31'd1 << 30;
            r_csum[0]  <= 31'd1 << 30;
            r_cy[0]    <= w_y[59:30];
            r_cside[0] <= i_side;
        end
    end

    for (genvar k = 1; k <= NT; k++) begin : g_term
        localparam logic [32:0] RECIP = 33'((64'd1 << 32) / k);
        logic [60:0] w_tp;
        logic [62:0] w_qp;
        logic [30:0] w_r;
        logic [29:0] w_q;

        assign w_tp = 61'(r_cterm[k-1]) * 61'(r_cy[k-1]);
        assign w_qp = 63'(r_av[k]) * 63'(RECIP);
        assign w_r  = 31'(r_bv[k]) - 31'(r_bq0[k] * 30'(k));
        assign w_q  = (w_r >= 31'(k)) ? r_bq0[k] + 30'd1 : r_bq0[k];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_avld[k] <= 1'b0;
                r_bvld[k] <= 1'b0;
                r_cvld[k] <= 1'b0;
            end else if (i_en) begin
                r_avld[k] <= r_cvld[k-1];
                r_bvld[k] <= r_avld[k];
                r_cvld[k] <= r_bvld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_av[k]    <= w_tp[59:30];
                r_ay[k]    <= r_cy[k-1];
                r_asum[k]  <= r_csum[k-1];
                r_aside[k] <= r_cside[k-1];
                r_bv[k]    <= r_av[k];
                r_bq0[k]   <= w_qp[61:32];
                r_by[k]    <= r_ay[k];
                r_bsum[k]  <= r_asum[k];
                r_bside[k] <= r_aside[k];
                r_cterm[k] <= 31'(w_q);
                r_cy[k]    <= r_by[k];
                r_csum[k]  <= r_bsum[k] + 31'(w_q);
                r_cside[k] <= r_bside[k];
            end
        end
    end

    assign o_vld  = r_cvld[NT];
    assign o_p    = r_csum[NT];
    assign o_side = r_cside[NT];

endmodule

### sv/peaking_eq_coefficient_generator_core.sv
// peaking eq biquad coefficient generator, fully pipelined
// throughput: one transaction per cycle; the whole pipeline holds when the output is stalled
// the depth is set by the bit-per-stage dividers, the cordic and the taylor series stages
// reset clears all valid bits and sets the sample rate register to 48000
module peaking_eq_coefficient_generator_core #(
    parameter int COEF_FRAC_BITS = 28,
    parameter int CORDIC_STAGES  = 24
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_wr_en,
    input  logic [17:0]  i_cfg_wr_data,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [47:0]  s_axis_tdata,   // centre_freq_hz[16:0], bandwidth_oct[32:17], gain_db[46:33]
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [159:0] m_axis_tdata,   // coef_b0, coef_b1, coef_b2, coef_a1, coef_a2, 32 bits each
    output logic [1:0]   m_axis_tuser    // status
);
    localparam int CS = CORDIC_STAGES;
    localparam int FB = COEF_FRAC_BITS;

    typedef struct packed {
        logic [15:0] bw;
        logic [32:0] e;
        logic        gneg;
        logic        bad;
    } t_s1;

    typedef struct packed {
        logic [31:0] omega;
        logic [15:0] bw;
        logic [32:0] e;
        logic        gneg;
        logic        bad;
        logic        flip;
    } t_s2;

    typedef struct packed {
        logic [30:0] s;
        logic [31:0] cm;
        logic        cpos;
        logic [32:0] e;
        logic        gneg;
        logic        bad;
    } t_s3;

    typedef struct packed {
        logic [5:0]  n;
        logic        asat;
        t_s3         b;
    } t_s4;

    typedef struct packed {
        logic [55:0] t1;
        logic        asat;
        logic [5:0]  n;
        logic [33:0] p;
        logic [31:0] cm;
        logic        cpos;
        logic        gneg;
        logic        bad;
    } t_s5;

    typedef struct packed {
        logic [54:0] alpha;
        logic        sat;
        logic [33:0] p;
        logic [31:0] cm;
        logic        cpos;
        logic        gneg;
        logic        bad;
    } t_s6;

    typedef struct packed {
        logic [59:0] mul;
        logic        sat;
        logic [31:0] cm;
        logic        cpos;
        logic        gneg;
        logic        bad;
    } t_s7;

    typedef struct packed {
        logic        neg1;
        logic        neg2;
        logic        neg4;
        logic        sat;
        logic        bad;
    } t_s8;

    logic        w_en;
    logic [17:0] r_fs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fs <= pecg_pkg::FS_RESET;
        end else if (i_cfg_wr_en) begin
            r_fs <= i_cfg_wr_data;
        end
    end

    logic r_out_vld;

    assign w_en          = !r_out_vld || m_axis_tready;
    assign s_axis_tready = w_en;
    assign m_axis_tvalid = r_out_vld;

    // ---------------- stage a: range check and gain exponent
    logic [16:0] w_f0;
    logic [13:0] w_g;
    logic [13:0] w_gmag;
    logic [41:0] w_ep;
    logic        r_a_vld;
    logic [16:0] r_a_f0;
    t_s1         r_a_side;

    assign w_f0   = s_axis_tdata[16:0];
    assign w_g    = s_axis_tdata[46:33];
    assign w_gmag = w_g[13] ? 14'(15'h4000 - {1'b0, w_g}) : w_g;
    assign w_ep   = 42'(w_gmag) * 42'(pecg_pkg::GAIN_EXP_Q30) + 42'd128;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (w_en) begin
            r_a_vld <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a_f0        <= w_f0;
            r_a_side.bw   <= s_axis_tdata[32:17];
            r_a_side.e    <= w_ep[40:8];
            r_a_side.gneg <= w_g[13];
            r_a_side.bad  <= (w_f0 == 17'd0) || ({w_f0, 1'b0} >= r_fs);
        end
    end

    // ---------------- turn = f0 * 2^32 / fs
    logic        w_d1_vld;
    logic [30:0] w_turn;
    logic        w_d1_ovf;
    t_s1         w_d1_side;

    pecg_div #(.NW(49), .DW(18), .QW(31), .PW($bits(t_s1))) u_div_turn (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (w_en),
        .i_vld  (r_a_vld),
        .i_n    ({r_a_f0, 32'd0}),
        .i_d    (r_fs),
        .i_side (r_a_side),
        .o_vld  (w_d1_vld),
        .o_q    (w_turn),
        .o_ovf  (w_d1_ovf),
        .o_side (w_d1_side)
    );

    // ---------------- stage b: omega in q30
    logic [63:0] w_b_prod;
    logic        r_b_vld;
    logic [31:0] r_b_omega;
    t_s1         r_b_side;

    assign w_b_prod = 64'(w_turn) * 64'(pecg_pkg::TWO_PI_LO) + 64'h8000_0000;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else if (w_en) begin
            r_b_vld <= w_d1_vld;
        end
    end

    // overflow only for the pass-through case, whose result is replaced
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_b_omega    <= 32'(w_turn) + w_b_prod[63:32];
            r_b_side     <= w_d1_side;
            r_b_side.bad <= w_d1_side.bad | w_d1_ovf;
        end
    end

    // ---------------- cordic, angle folded into the first quadrant
    logic               r_cv   [0:CS];
    logic signed [33:0] r_cx   [0:CS];
    logic signed [33:0] r_cy   [0:CS];
    logic signed [33:0] r_cz   [0:CS];
    t_s2                r_cside[0:CS];
    logic               w_flip;

    assign w_flip = (r_b_omega > pecg_pkg::HALF_PI_Q30);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cv[0] <= 1'b0;
        end else if (w_en) begin
            r_cv[0] <= r_b_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_cx[0]          <= 34'(pecg_pkg::KINV_Q30);
            r_cy[0]          <= '0;
            r_cz[0]          <= w_flip ? 34'(pecg_pkg::PI_Q30) - 34'(r_b_omega)
                                       : 34'(r_b_omega);
            r_cside[0].omega <= r_b_omega;
            r_cside[0].bw    <= r_b_side.bw;
            r_cside[0].e     <= r_b_side.e;
            r_cside[0].gneg  <= r_b_side.gneg;
            r_cside[0].bad   <= r_b_side.bad;
            r_cside[0].flip  <= w_flip;
        end
    end

    for (genvar i = 0; i < CS; i++) begin : g_cordic
        logic signed [33:0] w_xs;
        logic signed [33:0] w_ys;
        logic signed [33:0] w_at;
        logic               w_pos;

        assign w_xs  = r_cx[i] >>> i;
        assign w_ys  = r_cy[i] >>> i;
        assign w_at  = 34'(pecg_pkg::ATAN_Q30[i]);
        assign w_pos = !r_cz[i][33];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_cv[i+1] <= 1'b0;
            end else if (w_en) begin
                r_cv[i+1] <= r_cv[i];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_cx[i+1]    <= w_pos ? r_cx[i] - w_ys : r_cx[i] + w_ys;
                r_cy[i+1]    <= w_pos ? r_cy[i] + w_xs : r_cy[i] - w_xs;
                r_cz[i+1]    <= w_pos ? r_cz[i] - w_at : r_cz[i] + w_at;
                r_cside[i+1] <= r_cside[i];
            end
        end
    end

    // ---------------- stage d: clamp sine and cosine, sinh numerator
    logic signed [33:0] w_cx;
    logic signed [33:0] w_cyv;
    logic [30:0]        w_s;
    logic [30:0]        w_xc;
    t_s2                w_cs;
    logic               r_d_vld;
    logic [47:0]        r_d_nu;
    t_s3                r_d_side;

    assign w_cx  = r_cx[CS];
    assign w_cyv = r_cy[CS];
    assign w_cs  = r_cside[CS];
    assign w_s   = (w_cyv < 34'sd1) ? 31'd1 :
                   (w_cyv > 34'sd1073741824) ? 31'd1073741824 : w_cyv[30:0];
    assign w_xc  = w_cx[33] ? 31'd0 :
                   (w_cx > 34'sd1073741824) ? 31'd1073741824 : w_cx[30:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_vld <= 1'b0;
        end else if (w_en) begin
            r_d_vld <= r_cv[CS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_d_nu        <= 48'(w_cs.omega) * 48'(w_cs.bw);
            r_d_side.s    <= w_s;
            r_d_side.cm   <= {w_xc, 1'b0};
            r_d_side.cpos <= !w_cs.flip && (w_xc != 31'd0);
            r_d_side.e    <= w_cs.e;
            r_d_side.gneg <= w_cs.gneg;
            r_d_side.bad  <= w_cs.bad;
        end
    end

    // ---------------- u = bw * omega / (2 sin) in q30
    logic        w_d2_vld;
    logic [36:0] w_d2_q;
    logic        w_d2_ovf;
    t_s3         w_d2_side;

    pecg_div #(.NW(66), .DW(31), .QW(37), .PW($bits(t_s3))) u_div_u (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (w_en),
        .i_vld  (r_d_vld),
        .i_n    ({r_d_nu, 18'd0}),
        .i_d    (r_d_side.s),
        .i_side (r_d_side),
        .o_vld  (w_d2_vld),
        .o_q    (w_d2_q),
        .o_ovf  (w_d2_ovf),
        .o_side (w_d2_side)
    );

    // ---------------- stage e: split u into integer and fraction
    logic [36:0] w_u;
    logic        r_e_vld;
    logic [29:0] r_e_f;
    t_s4         r_e_side;

    assign w_u = 37'((38'(w_d2_q) + 38'd1) >> 1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_vld <= 1'b0;
        end else if (w_en) begin
            r_e_vld <= w_d2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_e_f         <= w_u[29:0];
            r_e_side.n    <= w_u[35:30];
            r_e_side.asat <= w_d2_ovf || w_u[36] || (w_u[35:30] >= pecg_pkg::U_INT_MAX);
            r_e_side.b    <= w_d2_side;
        end
    end

    // ---------------- 2^frac(u) and 2^frac(gain exponent) side by side
    logic        w_xu_vld;
    logic [30:0] w_pf;
    t_s4         w_xu_side;
    logic        w_xg_vld;
    logic [30:0] w_pg;
    logic [1:0]  w_esh;

    pecg_exp2 #(.PW($bits(t_s4))) u_exp_u (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (w_en),
        .i_vld  (r_e_vld),
        .i_f    (r_e_f),
        .i_side (r_e_side),
        .o_vld  (w_xu_vld),
        .o_p    (w_pf),
        .o_side (w_xu_side)
    );

    pecg_exp2 #(.PW(2)) u_exp_g (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (w_en),
        .i_vld  (r_e_vld),
        .i_f    (r_e_side.b.e[29:0]),
        .i_side (r_e_side.b.e[31:30]),
        .o_vld  (w_xg_vld),
        .o_p    (w_pg),
        .o_side (w_esh)
    );

    // ---------------- stage f: sin * 2^frac, gain factor
    logic [61:0] w_f_m;
    logic        r_f_vld;
    logic [31:0] r_f_m;
    logic [30:0] r_f_pf;
    logic [33:0] r_f_p;
    t_s4         r_f_side;

    assign w_f_m = 62'(w_xu_side.b.s) * 62'(w_pf) + (62'd1 << 29);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_vld <= 1'b0;
        end else if (w_en) begin
            r_f_vld <= w_xu_vld & w_xg_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_f_m    <= w_f_m[61:30];
            r_f_pf   <= w_pf;
            r_f_p    <= 34'(w_pg) << w_esh;
            r_f_side <= w_xu_side;
        end
    end

    // ---------------- sin / 2^frac for the decaying exponential
    t_s5         w_s5;
    logic [56:0] w_mlim;
    logic        w_d3_vld;
    logic [31:0] w_d3_q;
    logic        w_d3_ovf;
    t_s5         w_d3_side;

    assign w_mlim      = (57'd1 << 55) >> r_f_side.n;
    assign w_s5.t1     = 56'(r_f_m) << r_f_side.n;
    assign w_s5.asat   = r_f_side.asat || (57'(r_f_m) > w_mlim);
    assign w_s5.n      = r_f_side.n;
    assign w_s5.p      = r_f_p;
    assign w_s5.cm     = r_f_side.b.cm;
    assign w_s5.cpos   = r_f_side.b.cpos;
    assign w_s5.gneg   = r_f_side.b.gneg;
    assign w_s5.bad    = r_f_side.b.bad;

    pecg_div #(.NW(62), .DW(31), .QW(32), .PW($bits(t_s5))) u_div_t2 (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (w_en),
        .i_vld  (r_f_vld),
        .i_n    ({r_f_side.b.s, 31'd0}),
        .i_d    (r_f_pf),
        .i_side (w_s5),
        .o_vld  (w_d3_vld),
        .o_q    (w_d3_q),
        .o_ovf  (w_d3_ovf),
        .o_side (w_d3_side)
    );

    // ---------------- stage h: alpha = (t1 - t2) / 2, capped
    logic [32:0] w_q3;
    logic [30:0] w_t2c;
    logic [30:0] w_t2;
    logic [56:0] w_adiff;
    logic [55:0] w_alpha;
    logic        w_acap;
    logic        r_h_vld;
    t_s6         r_h_side;

    assign w_q3    = 33'((34'(w_d3_q) + 34'd1) >> 1);
    assign w_t2c   = (w_d3_ovf || w_q3 > (33'd1 << 30)) ? (31'd1 << 30) : w_q3[30:0];
    assign w_t2    = w_t2c >> w_d3_side.n;
    assign w_adiff = 57'(w_d3_side.t1) - 57'(w_t2) + 57'd1;
    assign w_alpha = w_adiff[56:1];
    assign w_acap  = w_d3_side.asat || (w_alpha > (56'd1 << 54));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h_vld <= 1'b0;
        end else if (w_en) begin
            r_h_vld <= w_d3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_h_side.alpha <= w_acap ? (55'd1 << 54) : w_alpha[54:0];
            r_h_side.sat   <= w_acap;
            r_h_side.p     <= w_d3_side.p;
            r_h_side.cm    <= w_d3_side.cm;
            r_h_side.cpos  <= w_d3_side.cpos;
            r_h_side.gneg  <= w_d3_side.gneg;
            r_h_side.bad   <= w_d3_side.bad;
        end
    end

    // ---------------- stages i and j: alpha * p in q30, rounded
    logic        r_i_vld;
    logic [58:0] r_i_phi;
    logic [63:0] r_i_plo;
    t_s6         r_i_side;
    logic [64:0] w_lo_rnd;
    logic        r_j_vld;
    t_s6         r_j_side;
    t_s7         r_j_s7;

    assign w_lo_rnd = 65'(r_i_plo) + (65'd1 << 29);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_i_vld <= 1'b0;
            r_j_vld <= 1'b0;
        end else if (w_en) begin
            r_i_vld <= r_h_vld;
            r_j_vld <= r_i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_i_phi     <= 59'(r_h_side.alpha[54:30]) * 59'(r_h_side.p);
            r_i_plo     <= 64'(r_h_side.alpha[29:0]) * 64'(r_h_side.p);
            r_i_side    <= r_h_side;
            r_j_side    <= r_i_side;
            r_j_s7.mul  <= 60'(r_i_phi) + 60'(w_lo_rnd[64:30]);
            r_j_s7.sat  <= r_i_side.sat;
            r_j_s7.cm   <= r_i_side.cm;
            r_j_s7.cpos <= r_i_side.cpos;
            r_j_s7.gneg <= r_i_side.gneg;
            r_j_s7.bad  <= r_i_side.bad;
        end
    end

    // ---------------- alpha / p
    logic        w_d4_vld;
    logic [55:0] w_d4_q;
    logic        w_d4_ovf;
    t_s7         w_d4_side;

    pecg_div #(.NW(86), .DW(34), .QW(56), .PW($bits(t_s7))) u_div_ap (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (w_en),
        .i_vld  (r_j_vld),
        .i_n    ({r_j_side.alpha, 31'd0}),
        .i_d    (r_j_side.p),
        .i_side (r_j_s7),
        .o_vld  (w_d4_vld),
        .o_q    (w_d4_q),
        .o_ovf  (w_d4_ovf),
        .o_side (w_d4_side)
    );

    // ---------------- stage k: a0 and coefficient numerators
    localparam logic [59:0] ONE60 = 60'd1 << 30;

    logic [56:0] w_dq;
    logic [59:0] w_divres;
    logic [59:0] w_amul;
    logic [59:0] w_adiv;
    logic        r_k_vld;
    logic [59:0] r_k_a0;
    logic [59:0] r_k_mag [0:3];
    t_s8         r_k_side;

    assign w_dq     = 57'((58'(w_d4_q) + 58'd1) >> 1);
    assign w_divres = (w_d4_ovf || w_dq > (57'd1 << 55)) ? (60'd1 << 55) : 60'(w_dq);
    assign w_amul   = w_d4_side.gneg ? w_divres : w_d4_side.mul;
    assign w_adiv   = w_d4_side.gneg ? w_d4_side.mul : w_divres;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k_vld <= 1'b0;
        end else if (w_en) begin
            r_k_vld <= w_d4_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_k_a0        <= ONE60 + w_adiv;
            r_k_mag[0]    <= ONE60 + w_amul;
            r_k_mag[1]    <= 60'(w_d4_side.cm);
            r_k_mag[2]    <= (w_amul > ONE60) ? w_amul - ONE60 : ONE60 - w_amul;
            r_k_mag[3]    <= (w_adiv > ONE60) ? w_adiv - ONE60 : ONE60 - w_adiv;
            r_k_side.neg1 <= w_d4_side.cpos;
            r_k_side.neg2 <= (w_amul > ONE60);
            r_k_side.neg4 <= (w_adiv > ONE60);
            r_k_side.sat  <= w_d4_side.sat;
            r_k_side.bad  <= w_d4_side.bad;
        end
    end

    // ---------------- coefficient dividers: b0, b1 (= a1), b2, a2
    logic        w_cv    [0:3];
    logic [32:0] w_cq    [0:3];
    logic        w_covf  [0:3];
    t_s8         w_cside [0:3];

    for (genvar j = 0; j < 4; j++) begin : g_coef
        pecg_div #(.NW(60 + FB + 1), .DW(60), .QW(33), .PW($bits(t_s8))) u_div_coef (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (w_en),
            .i_vld  (r_k_vld),
            .i_n    ({r_k_mag[j], {(FB + 1){1'b0}}}),
            .i_d    (r_k_a0),
            .i_side (r_k_side),
            .o_vld  (w_cv[j]),
            .o_q    (w_cq[j]),
            .o_ovf  (w_covf[j]),
            .o_side (w_cside[j])
        );
    end

    // ---------------- stage l: round, saturate, sign and output register
    t_s8         w_fs;
    logic        w_neg  [0:3];
    logic [31:0] w_res  [0:3];
    logic        w_csat;
    logic [32:0] w_rq;
    logic [32:0] w_lim;
    logic        w_one_sat;
    logic [32:0] w_val;

    logic [159:0] r_out_data;
    logic [1:0]   r_out_status;

    assign w_fs     = w_cside[0];
    assign w_neg[0] = 1'b0;
    assign w_neg[1] = w_fs.neg1;
    assign w_neg[2] = w_fs.neg2;
    assign w_neg[3] = w_fs.neg4;

    always_comb begin
        w_csat    = 1'b0;
        w_rq      = '0;
        w_lim     = '0;
        w_one_sat = 1'b0;
        w_val     = '0;
        for (int j = 0; j < 4; j++) begin
            w_rq      = 33'((34'(w_cq[j]) + 34'd1) >> 1);
            w_lim     = w_neg[j] ? (33'd1 << 31) : ((33'd1 << 31) - 33'd1);
            w_one_sat = w_covf[j] || (w_rq > w_lim);
            w_val     = w_one_sat ? w_lim : w_rq;
            w_res[j]  = w_neg[j] ? 32'(33'd0 - w_val) : w_val[31:0];
            w_csat    = w_csat | w_one_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_out_vld <= w_cv[0] & w_cv[1] & w_cv[2] & w_cv[3];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (w_fs.bad) begin
                r_out_data   <= {128'd0, 32'd1 << FB};
                r_out_status <= pecg_pkg::STAT_BAD_F0;
            end else begin
                r_out_data   <= {w_res[3], w_res[1], w_res[2], w_res[1], w_res[0]};
                r_out_status <= (w_fs.sat || w_csat) ? pecg_pkg::STAT_SAT : pecg_pkg::STAT_OK;
            end
        end
    end

    assign m_axis_tdata = r_out_data;
    assign m_axis_tuser = r_out_status;

endmodule

### test/pecg_scoreboard.sv
`timescale 1ns / 1ps
// predicts coefficient sets from accepted requests and checks the result stream
module pecg_scoreboard
    import pecg_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_wr_en,
    input  logic [17:0]  i_cfg_wr_data,
    input  logic         i_req_valid,
    input  logic         i_req_ready,
    input  logic [47:0]  i_req_data,
    input  logic         i_coef_valid,
    input  logic         i_coef_ready,
    input  logic [159:0] i_coef_data,
    input  logic [1:0]   i_coef_status,
    output int           o_outstanding,
    output int           o_fail_count
);

    localparam int FRAC = 28;
    localparam int STAGES = 24;
    localparam longint unsigned ONE = 64'd1 << 30;
    localparam longint unsigned MASK = ONE - 1;
    localparam longint unsigned HALF = 64'd1 << 29;

    typedef struct packed {
        logic [159:0] coefs;
        logic [1:0]   status;
    } coef_set_t;

    coef_set_t       expected_sets [$];
    logic [17:0]     fs_reg;

    function automatic longint unsigned div_round(longint unsigned n, longint unsigned d,
                                                  int f, longint unsigned lim, inout bit sat);
        longint unsigned q, r;
        if (d == 0) begin
            sat = 1;
            return lim;
        end
        q = n / d;
        r = n % d;
        if (q > (lim >> f)) begin
            sat = 1;
            return lim;
        end
        for (int i = 0; i <= f; i++) begin
            r = r << 1;
            q = q << 1;
            if (r >= d) begin
                r = r - d;
                q = q | 1;
            end
        end
        q = (q + 1) >> 1;
        if (q > lim) begin
            sat = 1;
            q = lim;
        end
        return q;
    endfunction

    function automatic longint unsigned mul_fix(longint unsigned a, longint unsigned b);
        return (a >> 30) * b + (((a & MASK) * b + HALF) >> 30);
    endfunction

    // 2^frac by a 16 term series of e^(frac*ln2)
    function automatic longint unsigned pow2_frac(longint unsigned f);
        longint unsigned y, acc, term;
        y = ((f & MASK) * {34'd0, LN2_Q30} + HALF) >> 30;
        acc = ONE;
        term = ONE;
        for (int k = 1; k <= 16; k++) begin
            term = ((term * y) >> 30) / k;
            acc += term;
        end
        return acc;
    endfunction

    function automatic logic [31:0] scale_coef(bit neg, longint unsigned mag,
                                               longint unsigned den, inout bit sat);
        longint unsigned lim, q;
        lim = neg ? (64'd1 << 31) : ((64'd1 << 31) - 1);
        q = div_round(mag, den, FRAC, lim, sat);
        return neg ? 32'(-q) : 32'(q);
    endfunction

    function automatic coef_set_t peaking_coefs(logic [47:0] req, logic [17:0] fs_hz);
        longint unsigned f0, bw, graw, fs, turn, u, alpha, gmag, e, p, a_mul, a_div, a0, cm;
        longint unsigned pf, m, t1, t2;
        longint omega, x, y, z, nx, s, c;
        bit sat, usat, junk, gneg, flip;
        logic [31:0] b0, b1, b2, a2;
        coef_set_t res;
        f0 = req[16:0];
        bw = req[32:17];
        graw = req[46:33];
        fs = fs_hz;
        sat = 0;
        usat = 0;
        junk = 0;
        if (f0 == 0 || 2 * f0 >= fs) begin
            res.coefs = {128'd0, 32'd1 << FRAC};
            res.status = STAT_BAD_F0;
            return res;
        end
        turn = (f0 << 32) / fs;
        omega = longint'((turn * ({32'd1, 32'd0} + TWO_PI_LO) + (64'd1 << 31)) >> 32);

        // folded cordic rotation
        x = KINV_Q30;
        y = 0;
        z = omega;
        flip = 0;
        if (z > longint'(HALF_PI_Q30)) begin
            z = longint'(PI_Q30) - z;
            flip = 1;
        end
        for (int i = 0; i < STAGES; i++) begin
            if (z >= 0) begin
                nx = x - (y >>> i);
                y = y + (x >>> i);
                z -= ATAN_Q30[i];
            end else begin
                nx = x + (y >>> i);
                y = y - (x >>> i);
                z += ATAN_Q30[i];
            end
            x = nx;
        end
        if (y < 1) y = 1;
        if (y > longint'(ONE)) y = ONE;
        if (x < 0) x = 0;
        if (x > longint'(ONE)) x = ONE;
        s = y;
        c = flip ? -x : x;

        u = div_round(longint'(omega) * bw, s, 17, (64'd64 << 30) - 1, usat);
        if (usat || (u >> 30) >= U_INT_MAX) begin
            alpha = 64'd1 << 54;
            sat = 1;
        end else begin
            pf = pow2_frac(u & MASK);
            m = (s * pf + HALF) >> 30;
            if (m > ((64'd1 << 55) >> (u >> 30))) begin
                alpha = 64'd1 << 54;
                sat = 1;
            end else begin
                t2 = div_round(s, pf, 30, ONE, junk) >> (u >> 30);
                t1 = m << (u >> 30);
                alpha = (t1 - t2 + 1) >> 1;
                if (alpha > (64'd1 << 54)) begin
                    alpha = 64'd1 << 54;
                    sat = 1;
                end
            end
        end

        // linear gain 10^(|g|/40)
        gneg = graw[13];
        gmag = gneg ? (64'h4000 - graw) : graw;
        e = (gmag * GAIN_EXP_Q30 + 128) >> 8;
        p = pow2_frac(e & MASK) << ((e >> 30) & 3);
        if (!gneg) begin
            a_mul = mul_fix(alpha, p);
            a_div = div_round(alpha, p, 30, 64'd1 << 55, junk);
        end else begin
            a_mul = div_round(alpha, p, 30, 64'd1 << 55, junk);
            a_div = mul_fix(alpha, p);
        end
        a0 = ONE + a_div;
        cm = 2 * longint'(c < 0 ? -c : c);

        b0 = scale_coef(0, ONE + a_mul, a0, sat);
        b1 = scale_coef(c > 0, cm, a0, sat);
        b2 = a_mul > ONE ? scale_coef(1, a_mul - ONE, a0, sat)
                         : scale_coef(0, ONE - a_mul, a0, sat);
        a2 = a_div > ONE ? scale_coef(1, a_div - ONE, a0, sat)
                         : scale_coef(0, ONE - a_div, a0, sat);
        res.coefs = {a2, b1, b2, b1, b0};
        res.status = sat ? STAT_SAT : STAT_OK;
        return res;
    endfunction

    assign o_outstanding = expected_sets.size();

    always @(posedge i_clk) begin
        coef_set_t want;
        if (!i_rst_n) begin
            fs_reg <= FS_RESET;
            o_fail_count <= 0;
        end else begin
            if (i_cfg_wr_en)
                fs_reg <= i_cfg_wr_data;
            if (i_req_valid && i_req_ready)
                expected_sets.push_back(peaking_coefs(i_req_data, fs_reg));
            if (i_coef_valid && i_coef_ready) begin
                if (expected_sets.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("%t: unexpected result transaction %h", $realtime, i_coef_data);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = expected_sets.pop_front();
                    if (want.coefs !== i_coef_data || want.status !== i_coef_status) begin
                        if (o_fail_count < 10)
                            for (int k = 0; k < 5; k++)
                                $display("%t: coef %0d expected %h got %h, status %0d got %0d",
                                         $realtime, k, want.coefs[32*k +: 32],
                                         i_coef_data[32*k +: 32], want.status, i_coef_status);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

### test/tb_peaking_eq_coefficient_generator_core.sv
`timescale 1ns / 1ps
// stimulus and verdict for the peaking eq coefficient generator
module tb_peaking_eq_coefficient_generator_core;
    import pecg_pkg::*;

    logic         i_clk;
    logic         i_rst_n;
    logic         i_cfg_wr_en;
    logic [17:0]  i_cfg_wr_data;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [47:0]  s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [159:0] m_axis_tdata;
    logic [1:0]   m_axis_tuser;
    int           outstanding;
    int           fail_count;
    int           send_idle_pct;
    int           recv_stall_pct;
    logic [17:0]  fs_now;

    localparam logic [17:0] FS_SET [0:7] = '{18'd48000, 18'd8000, 18'd192000, 18'd262143,
                                             18'd44100, 18'd0, 18'd96000, 18'd8000};

    peaking_eq_coefficient_generator_core u_top (.*);

    pecg_scoreboard u_scoreboard (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_wr_en(i_cfg_wr_en), .i_cfg_wr_data(i_cfg_wr_data),
        .i_req_valid(s_axis_tvalid), .i_req_ready(s_axis_tready), .i_req_data(s_axis_tdata),
        .i_coef_valid(m_axis_tvalid), .i_coef_ready(m_axis_tready),
        .i_coef_data(m_axis_tdata), .i_coef_status(m_axis_tuser),
        .o_outstanding(outstanding), .o_fail_count(fail_count)
    );

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5ms;
        $display("Mismatches found");
        $finish;
    end

    always @(posedge i_clk)
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);

    task automatic send_request(logic [16:0] f0, logic [15:0] bw, logic [13:0] gain);
        s_axis_tvalid <= 1;
        s_axis_tdata <= {1'b0, gain, bw, f0};
        do @(posedge i_clk); while (!s_axis_tready);
        if ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
    endtask

    task automatic drain_pipeline();
        s_axis_tvalid <= 0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
    endtask

    initial begin
        logic [16:0] f0;
        logic [16:0] nyq;
        s_axis_tvalid = 0;
        s_axis_tdata = '0;
        i_cfg_wr_en = 0;
        i_cfg_wr_data = '0;
        m_axis_tready = 1;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        fs_now = FS_RESET;
        i_rst_n = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // corner requests at the reset sample rate
        send_request(17'd0, 16'd4096, 14'd0);
        send_request(17'd24000, 16'd4096, 14'd256);
        send_request(17'd23999, 16'd4096, 14'd256);
        send_request(17'd131071, 16'd4096, 14'd0);
        send_request(17'd1, 16'd4096, 14'd1536);
        send_request(17'd1, 16'd65535, 14'h3fff);
        send_request(17'd1000, 16'd0, 14'd6144);
        send_request(17'd1000, 16'd65535, 14'd6144);
        send_request(17'd1000, 16'd1, -14'sd6144);
        send_request(17'd1000, 16'd4096, 14'h1fff);
        send_request(17'd1000, 16'd4096, 14'h2000);
        send_request(17'd12000, 16'd4096, 14'd0);
        send_request(17'd12001, 16'd2048, 14'd3072);
        send_request(17'd23990, 16'd4096, 14'd3072);
        send_request(17'd20000, 16'd65535, -14'sd3072);
        send_request(17'd5, 16'd40000, 14'd100);
        send_request(17'd300, 16'd512, 14'h2a55);
        drain_pipeline();

        for (int ph = 0; ph < 8; ph++) begin
            fs_now = FS_SET[ph];
            i_cfg_wr_en <= 1;
            i_cfg_wr_data <= fs_now;
            @(posedge i_clk);
            i_cfg_wr_en <= 0;
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 88; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 88; end
                default: begin send_idle_pct = 21; recv_stall_pct = 21; end
            endcase
            nyq = (fs_now >> 1) > 0 ? 17'((fs_now >> 1) - 1) : 17'd0;
            for (int n = 0; n < 110; n++) begin
                // mostly valid centre frequencies, some out of range
                if ($urandom_range(9) == 0 || nyq == 0)
                    f0 = 17'($urandom);
                else if ($urandom_range(9) == 0)
                    f0 = 17'($urandom_range(nyq, nyq > 20 ? nyq - 20 : 1));
                else
                    f0 = 17'($urandom_range(nyq, 1));
                send_request(f0,
                             $urandom_range(3) == 0 ? 16'($urandom) : 16'($urandom_range(8192, 1)),
                             $urandom_range(7) == 0 ? 14'($urandom)
                                                    : 14'($urandom_range(12288) - 6144));
            end
            drain_pipeline();
        end

        if (fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

### peaking_eq_coefficient_generator_core.f
sv/pecg_pkg.sv
sv/pecg_div.sv
sv/pecg_exp2.sv
sv/peaking_eq_coefficient_generator_core.sv
test/pecg_scoreboard.sv
test/tb_peaking_eq_coefficient_generator_core.sv
